>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/dtp_pkg.sv
`timescale 1ns / 1ps

package dtp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NO_NUMBER = 3'd2,
        ST_NUM_OVF   = 3'd3,
        ST_BAD_UNIT  = 3'd4,
        ST_TOTAL_OVF = 3'd5
    } t_status;

    // Character codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_WEEK   = 8'h77;  // w
    localparam logic [7:0] CH_DAY    = 8'h64;  // d
    localparam logic [7:0] CH_HOUR   = 8'h48;  // H
    localparam logic [7:0] CH_MINUTE = 8'h4D;  // M

    // Unit factors in seconds
    localparam int         FACTOR_W   = 20;
    localparam logic [FACTOR_W-1:0] SEC_MINUTE = 20'd60;
    localparam logic [FACTOR_W-1:0] SEC_HOUR   = 20'd3600;
    localparam logic [FACTOR_W-1:0] SEC_DAY    = 20'd86400;
    localparam logic [FACTOR_W-1:0] SEC_WEEK   = 20'd604800;

    localparam int VALUE_W = 64;

    // One input transaction
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [VALUE_W-1:0] total_seconds;
        t_status            status;
    } t_result;

    // Parser control state visible to the top level
    typedef struct packed {
        logic    any_char_seen;
        logic    digits_seen;
        t_status error_code;
    } t_core_status;

endpackage

>>> rtl/dtp_in_stage.sv
`timescale 1ns / 1ps

module dtp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  dtp_pkg::t_item i_item,
    input  logic           i_step,
    output logic           o_item_valid,
    output dtp_pkg::t_item o_item
);
    import dtp_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    logic  w_accept;

    // Hold while the parser cannot take the registered item
    assign o_stall  = r_valid && !i_step;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_step) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> rtl/dtp_core.sv
`timescale 1ns / 1ps

module dtp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  dtp_pkg::t_item        i_item,
    output dtp_pkg::t_result      o_result,
    output dtp_pkg::t_core_status o_status
);
    import dtp_pkg::*;

    localparam int WIDE_W = VALUE_W + FACTOR_W;

    logic [VALUE_W-1:0] r_number, n_number;
    logic [VALUE_W-1:0] r_total, n_total;
    logic               r_digits, n_digits;
    logic               r_any, n_any;
    t_status            r_err, n_err;

    logic               w_is_digit;
    logic [VALUE_W+3:0] w_num10;
    logic [WIDE_W-1:0]  w_term_w, w_term_d, w_term_h, w_term_m, w_term;
    logic               w_unit_ok;
    logic [VALUE_W:0]   w_sum;
    logic               w_term_ovf;
    t_status            w_fin_err;
    logic [VALUE_W-1:0] w_fin_total;

    // Digit accumulate: number * 10 + digit, with carry-out for overflow
    assign w_is_digit = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
    assign w_num10 = ({4'b0, r_number} << 3) + ({4'b0, r_number} << 1)
                   + {{(VALUE_W){1'b0}}, i_item.char_code[3:0]};

    // Constant unit products
    assign w_term_w = {{FACTOR_W{1'b0}}, r_number} * {{VALUE_W{1'b0}}, SEC_WEEK};
    assign w_term_d = {{FACTOR_W{1'b0}}, r_number} * {{VALUE_W{1'b0}}, SEC_DAY};
    assign w_term_h = {{FACTOR_W{1'b0}}, r_number} * {{VALUE_W{1'b0}}, SEC_HOUR};
    assign w_term_m = {{FACTOR_W{1'b0}}, r_number} * {{VALUE_W{1'b0}}, SEC_MINUTE};

    // Unit select; the end marker closes a bare number as hours
    always_comb begin
        w_unit_ok = 1'b1;
        w_term    = w_term_h;
        if (!i_item.end_of_text) begin
            case (i_item.char_code)
                CH_WEEK:   w_term = w_term_w;
                CH_DAY:    w_term = w_term_d;
                CH_HOUR:   w_term = w_term_h;
                CH_MINUTE: w_term = w_term_m;
                default:   w_unit_ok = 1'b0;
            endcase
        end
    end

    assign w_sum      = {1'b0, r_total} + {1'b0, w_term[VALUE_W-1:0]};
    assign w_term_ovf = (w_term[WIDE_W-1:VALUE_W] != '0) || w_sum[VALUE_W];

    // Closing of a text on the end marker
    always_comb begin
        w_fin_err   = r_err;
        w_fin_total = r_total;
        if (r_err == ST_OK) begin
            if (!r_any) begin
                w_fin_err = ST_EMPTY;
            end else if (r_digits) begin
                if (w_term_ovf) begin
                    w_fin_err = ST_TOTAL_OVF;
                end else begin
                    w_fin_total = w_sum[VALUE_W-1:0];
                end
            end
        end
    end

    assign o_result.total_seconds = (w_fin_err == ST_OK) ? w_fin_total : '0;
    assign o_result.status        = w_fin_err;

    // Next state
    always_comb begin
        n_number = r_number;
        n_total  = r_total;
        n_digits = r_digits;
        n_any    = r_any;
        n_err    = r_err;
        if (i_step) begin
            if (i_item.end_of_text) begin
                n_number = '0;
                n_total  = '0;
                n_digits = 1'b0;
                n_any    = 1'b0;
                n_err    = ST_OK;
            end else begin
                n_any = 1'b1;
                if (r_err == ST_OK) begin
                    if (w_is_digit) begin
                        if (w_num10[VALUE_W+3:VALUE_W] != '0) begin
                            n_err = ST_NUM_OVF;
                        end else begin
                            n_number = w_num10[VALUE_W-1:0];
                            n_digits = 1'b1;
                        end
                    end else if (!r_digits) begin
                        n_err = ST_NO_NUMBER;
                    end else if (!w_unit_ok) begin
                        n_err = ST_BAD_UNIT;
                    end else if (w_term_ovf) begin
                        n_err = ST_TOTAL_OVF;
                    end else begin
                        n_total  = w_sum[VALUE_W-1:0];
                        n_number = '0;
                        n_digits = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number <= '0;
            r_total  <= '0;
            r_digits <= 1'b0;
            r_any    <= 1'b0;
            r_err    <= ST_OK;
        end else begin
            r_number <= n_number;
            r_total  <= n_total;
            r_digits <= n_digits;
            r_any    <= n_any;
            r_err    <= n_err;
        end
    end

    assign o_status.any_char_seen = r_any;
    assign o_status.digits_seen   = r_digits;
    assign o_status.error_code    = r_err;

endmodule

>>> rtl/dtp_out_stage.sv
`timescale 1ns / 1ps

module dtp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dtp_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output dtp_pkg::t_result o_result
);
    import dtp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    // Slot can take a new result when empty or being drained this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/duration_text_parser.sv
// Path: an end-marker transaction passes through the input register, then the result
//   register, to o_valid; it waits in the input register while an earlier result waits on
//   a stalled output.
// Throughput: one transaction per cycle; the digit and unit update of the parser state
//   is combinational, and o_stall rises only when a result waits on a stalled output.
// Reset: synchronous, active low; clears valids and the parser state to an empty text.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module duration_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_total_seconds,
    output logic [2:0]  o_status
);
    import dtp_pkg::*;

    t_item        w_in_item, w_item;
    logic         w_item_valid;
    logic         w_step, w_load, w_out_free;
    t_result      w_core_result, w_out_result;
    t_core_status w_core_status;
    logic         w_core_clear;
    t_status      w_core_err;

    assign w_in_item.char_code   = i_char_code;
    assign w_in_item.end_of_text = i_end_of_text;

    // Input register
    dtp_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (w_in_item),
        .i_step       (w_step),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    // A byte always advances; an end marker needs a free result slot
    assign w_step = w_item_valid && (!w_item.end_of_text || w_out_free);
    assign w_load = w_step && w_item.end_of_text;

    // Parser state and datapath
    dtp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_item),
        .o_result (w_core_result),
        .o_status (w_core_status)
    );

    // Result register
    dtp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_core_result),
        .i_stall  (i_stall),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .o_result (w_out_result)
    );

    assign o_total_seconds = w_out_result.total_seconds;
    assign o_status        = w_out_result.status;

    // Parser state summaries for the checks
    assign w_core_err   = w_core_status.error_code;
    assign w_core_clear = !w_core_status.any_char_seen && !w_core_status.digits_seen
                        && (w_core_err == ST_OK);

    // Checks
    `ASSERT_NEXT(a_clear_on_end, w_load, w_core_clear)
    `ASSERT_NEXT(a_err_latched, (w_core_err != ST_OK) && !w_load, w_core_err == $past(w_core_err))
    `ASSERT_IMPL(a_zero_on_err, o_valid && (o_status != ST_OK), o_total_seconds == '0)
    `ASSERT_IMPL(a_no_overwrite, o_valid && i_stall, !w_load)

endmodule
